// ===== design/srle_pkg.sv =====
// Shared types, constants and helpers for the S-record line encoder.
package srle_pkg;

    // Command codes of an input item
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Depth of the job queue between front and back
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // Character positions within a record line
    localparam logic [3:0] STEP_SYNC    = 4'd0;
    localparam logic [3:0] STEP_TYPE    = 4'd1;
    localparam logic [3:0] STEP_CNT_HI  = 4'd2;
    localparam logic [3:0] STEP_CNT_LO  = 4'd3;
    localparam logic [3:0] STEP_AHI_HI  = 4'd4;
    localparam logic [3:0] STEP_AHI_LO  = 4'd5;
    localparam logic [3:0] STEP_BYTE_HI = 4'd6;
    localparam logic [3:0] STEP_BYTE_LO = 4'd7;
    localparam logic [3:0] STEP_CK_HI   = 4'd8;
    localparam logic [3:0] STEP_CK_LO   = 4'd9;

    localparam logic [7:0] CHAR_S       = 8'h53;
    localparam logic [7:0] CK_INVERT    = 8'hFF;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  record_type;
        logic [15:0] load_address;
        logic [7:0]  byte_count;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
        logic       record_done;
    } t_out_item;

    // One unit of work for the back end
    typedef struct packed {
        logic       is_data;   // data pair, else full header; has_ck adds ck
        logic [3:0] rtype;
        logic [7:0] ccount;
        logic [7:0] ahi;
        logic [7:0] lo_byte;   // address low byte or data byte
        logic       has_ck;
        logic [7:0] ck;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

// ===== design/srle_front.sv =====
// Front end: accepts items, tracks the open record and builds jobs.
module srle_front #(
    parameter int MAX_DATA_BYTES = 252
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  srle_pkg::t_in_item i_item,
    output logic              o_job_push,
    output srle_pkg::t_job    o_job
);
    import srle_pkg::*;

    localparam logic [7:0] MAX_CNT = 8'(MAX_DATA_BYTES);

    logic       r_in_record;
    logic [7:0] r_bytes_left;
    logic [7:0] r_sum;

    logic [7:0] sat_cnt;
    logic [7:0] ccount;
    logic [7:0] hdr_sum;
    logic [7:0] data_sum;
    logic [7:0] left_dec;

    always_comb begin
        sat_cnt  = (i_item.byte_count > MAX_CNT) ? MAX_CNT : i_item.byte_count;
        ccount   = sat_cnt + 8'd3;
        hdr_sum  = ccount + i_item.load_address[15:8] + i_item.load_address[7:0];
        data_sum = r_sum + i_item.data_byte;
        left_dec = r_bytes_left - 8'd1;

        o_job.rtype  = i_item.record_type;
        o_job.ccount = ccount;
        o_job.ahi    = i_item.load_address[15:8];
        if (i_item.cmd == CMD_BEGIN) begin
            o_job.is_data = 1'b0;
            o_job.lo_byte = i_item.load_address[7:0];
            o_job.has_ck  = (sat_cnt == 8'd0);
            o_job.ck      = hdr_sum ^ CK_INVERT;
            o_job_push    = i_accept;
        end else begin
            o_job.is_data = 1'b1;
            o_job.lo_byte = i_item.data_byte;
            o_job.has_ck  = (left_dec == 8'd0);
            o_job.ck      = data_sum ^ CK_INVERT;
            // data outside a record is dropped
            o_job_push    = i_accept && r_in_record;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_record  <= 1'b0;
            r_bytes_left <= 8'd0;
            r_sum        <= 8'd0;
        end else if (i_accept) begin
            if (i_item.cmd == CMD_BEGIN) begin
                r_in_record  <= (sat_cnt != 8'd0);
                r_bytes_left <= sat_cnt;
                r_sum        <= hdr_sum;
            end else if (r_in_record) begin
                r_in_record  <= (left_dec != 8'd0);
                r_bytes_left <= left_dec;
                r_sum        <= data_sum;
            end
        end
    end

endmodule

// ===== design/srle_queue.sv =====
// Short job queue between front and back ends.
module srle_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  srle_pkg::t_job   i_job,
    input  logic             i_pop,
    output srle_pkg::t_job   o_job,
    output srle_pkg::t_q_stat o_stat
);
    import srle_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    always_comb begin
        o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
        o_stat.empty = (r_count == '0);
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        o_job        = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/srle_back.sv =====
// Back end: walks jobs to the output reg one char per cycle unless stalled.
module srle_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srle_pkg::t_job     i_job,
    input  srle_pkg::t_q_stat  i_q_stat,
    output logic               o_take,
    input  logic               i_pop,
    output logic               o_empty,
    output srle_pkg::t_out_item o_item
);
    import srle_pkg::*;

    t_job       r_job;
    logic       r_busy;
    logic [3:0] r_step;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       adv;
    logic       emit;
    logic       last;
    logic [3:0] end_step;
    logic [3:0] nib;
    t_out_item  n_out;

    always_comb begin
        adv      = !r_out_valid || i_pop;
        emit     = r_busy && adv;
        end_step = r_job.has_ck ? STEP_CK_LO : STEP_BYTE_LO;
        last     = (r_step == end_step);
        o_take   = !i_q_stat.empty && (!r_busy || (emit && last));

        case (r_step)
            STEP_TYPE:    nib = r_job.rtype;
            STEP_CNT_HI:  nib = r_job.ccount[7:4];
            STEP_CNT_LO:  nib = r_job.ccount[3:0];
            STEP_AHI_HI:  nib = r_job.ahi[7:4];
            STEP_AHI_LO:  nib = r_job.ahi[3:0];
            STEP_BYTE_HI: nib = r_job.lo_byte[7:4];
            STEP_BYTE_LO: nib = r_job.lo_byte[3:0];
            STEP_CK_HI:   nib = r_job.ck[7:4];
            STEP_CK_LO:   nib = r_job.ck[3:0];
            default:      nib = 4'd0;
        endcase

        n_out.out_char    = (r_step == STEP_SYNC) ? CHAR_S : hex_char(nib);
        n_out.last_of_run = last;
        n_out.record_done = (r_step == STEP_CK_LO);

        o_empty = !r_out_valid;
        o_item  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_SYNC;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_busy <= 1'b1;
                r_step <= i_job.is_data ? STEP_BYTE_HI : STEP_SYNC;
            end else if (emit) begin
                r_busy <= !last;
                r_step <= r_step + 4'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== design/srecord_line_encoder.sv =====
// Top level of the S-record line encoder: front end, job queue, back end.
// An accepted item is queued, then loaded into the back end's job register, then
// its characters enter the single output register, one per cycle unless stalled.
// A header gives S, type, count, address; a data item its byte; then any checksum.
// Reset (synchronous, active low) empties the queue and output, closes any record.
module srecord_line_encoder #(
    parameter int MAX_DATA_BYTES = 252
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  srle_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output srle_pkg::t_out_item o_out_item
);
    import srle_pkg::*;

    // front -> queue
    logic    job_push;
    t_job    front_job;
    // queue -> back
    t_job    q_job;
    t_q_stat q_stat;
    logic    take;

    // An item is taken whenever the queue has room; dropped data still counts.
    assign full = q_stat.full;

    srle_front #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !q_stat.full),
        .i_item     (i_in_item),
        .o_job_push (job_push),
        .o_job      (front_job)
    );

    // Decouples item intake from character output.
    srle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_pop   (take),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    // Loads the next job on the last character of the current one: no bubble.
    srle_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (q_job),
        .i_q_stat (q_stat),
        .o_take   (take),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_item   (o_out_item)
    );

endmodule
